@@ rtl/mvs_pkg.sv @@
// Shared constants, codes, control structs and the quarter-wave sine table
// for the polyphonic synth mixer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mvs_pkg;

   localparam int NUM_VOICES = 16;
   localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

   localparam int SINE_DEPTH = 256;
   localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
   localparam int QTR = SINE_DEPTH / 4;
   localparam int QTR_W = SINE_IDX_W - 2;   // index within one quarter

   localparam int MAG_W = 17;               // wave magnitude, up to 32768
   localparam int PROD_W = 58;
   localparam int SUM_W = 20 + VIDX_W;

   localparam logic [23:0] ONE_Q23 = 24'h800000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_VOLUME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_SAMPLES = 3'd5;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_PLAY = 2'd1;
   localparam logic [1:0] FUNC_STOP = 2'd2;

   localparam logic [2:0] WAVE_SINE = 3'd0;
   localparam logic [2:0] WAVE_SQUARE = 3'd1;
   localparam logic [2:0] WAVE_SAW = 3'd2;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd3;

   typedef enum logic [2:0] {
      ST_ATTACK, ST_DECAY, ST_SUSTAIN, ST_RELEASE, ST_DONE
   } env_stage_type;

   typedef enum logic [1:0] {
      MUL_AMP, MUL_ENV, MUL_VOL
   } mul_sel_type;

   typedef struct packed {
      logic              take;     // request accepted this edge
      logic              load;     // fetch voice state into working regs
      logic              env;      // envelope step, wave pick, write back
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              acc;
      logic              push;     // result register loads, play/stop act
      logic [VIDX_W-1:0] vidx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       active;          // voice at vidx is active
      logic       freed;           // voice at vidx ends on this tick
   } dp_status_type;

   typedef logic [QTR:0][16:0] sine_tab_type;

   // sin of num/SINE_DEPTH quarter turns, Taylor series in Q30, result Q1.15
   function automatic logic [16:0] quarter_sine(longint unsigned num);
      longint unsigned x, x2, t1, t2, t3, t4, t5, t6, pos, neg, s;
      x = (num * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t1 = ((x * x2) >> 30) / 64'd6;
      t2 = ((t1 * x2) >> 30) / 64'd20;
      t3 = ((t2 * x2) >> 30) / 64'd42;
      t4 = ((t3 * x2) >> 30) / 64'd72;
      t5 = ((t4 * x2) >> 30) / 64'd110;
      t6 = ((t5 * x2) >> 30) / 64'd156;
      pos = x + t2 + t4 + t6;
      neg = t1 + t3 + t5;
      s = (pos > neg) ? pos - neg : 64'd0;
      s = (s + 64'd16384) >> 15;
      return (s > 64'd32768) ? 17'd32768 : 17'(s);
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      for (int i = 0; i <= QTR; i++) begin
         t[i] = quarter_sine(64'(4 * i));
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

@@ rtl/mvs_if.sv @@
// Request and response channel interfaces for the synth mixer.
// Has no dependencies; the field widths, voice_index included, are written out.
`timescale 1ns / 1ps
`default_nettype none
interface mvs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [2:0]  wave_type;
   logic [31:0] phase_step;
   logic [15:0] amplitude;
   logic [31:0] duration;
   modport source (output valid, func, wave_type, phase_step, amplitude, duration,
                   input ready);
   modport sink (input valid, func, wave_type, phase_step, amplitude, duration,
                 output ready);
endinterface

interface mvs_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] sample;
   logic [3:0]        voice_index;
   logic              no_free_voice;
   modport source (output valid, sample, voice_index, no_free_voice, input ready);
   modport sink (input valid, sample, voice_index, no_free_voice, output ready);
endinterface
`default_nettype wire

@@ rtl/mvs_ctrl.sv @@
// Sequencer for the synth mixer: walks the voices on a tick, steps the shared
// multiplier and owns the handshakes. Depends on mvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvs_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire mvs_pkg::dp_status_type status,
   output mvs_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_LOAD, S_ENV, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_DONE
   } state_type;

   localparam logic [mvs_pkg::VIDX_W-1:0] LAST = mvs_pkg::VIDX_W'(mvs_pkg::NUM_VOICES - 1);

   state_type state_ff;
   logic [mvs_pkg::VIDX_W-1:0] cnt_ff;
   logic rsp_valid_ff;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.vidx = cnt_ff;
      cmd.take = (state_ff == S_IDLE) && req_valid;
      cmd.load = (state_ff == S_LOAD);
      cmd.env = (state_ff == S_ENV);
      cmd.acc = (state_ff == S_ACC);
      cmd.push = (state_ff == S_DONE) && slot_free;
      cmd.mul_sel = mvs_pkg::MUL_AMP;
      case (state_ff)
         S_MUL1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = mvs_pkg::MUL_AMP;
         end
         S_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = mvs_pkg::MUL_ENV;
         end
         S_MUL3: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = mvs_pkg::MUL_VOL;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.push) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_START;
            end
            S_START: begin
               cnt_ff <= '0;
               state_ff <= (status.func == mvs_pkg::FUNC_TICK) ? S_LOAD : S_DONE;
            end
            S_LOAD: begin
               if (status.active) state_ff <= S_ENV;
               else if (cnt_ff == LAST) state_ff <= S_DONE;
               else cnt_ff <= cnt_ff + 1'b1;
            end
            S_ENV: begin
               if (!status.freed) state_ff <= S_MUL1;
               else if (cnt_ff == LAST) state_ff <= S_DONE;
               else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_LOAD;
               end
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_MUL3;
            S_MUL3: state_ff <= S_ACC;
            S_ACC: begin
               if (cnt_ff == LAST) state_ff <= S_DONE;
               else begin
                  cnt_ff <= cnt_ff + 1'b1;
                  state_ff <= S_LOAD;
               end
            end
            S_DONE: begin
               if (slot_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/mvs_datapath.sv @@
// Voice state, envelope step, wave shaper, shared multiplier, mixer and
// result register for the synth mixer. Depends on mvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mvs_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mvs_pkg::ctrl_cmd_type             cmd,
   output mvs_pkg::dp_status_type                 status,
   input  wire logic                              csr_we,
   input  wire logic [mvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mvs_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic [1:0]                        req_func,
   input  wire logic [2:0]                        req_wave,
   input  wire logic [31:0]                       req_step,
   input  wire logic [15:0]                       req_amp,
   input  wire logic [31:0]                       req_dur,
   output logic signed [15:0]                     rsp_sample,
   output logic [3:0]                             rsp_index,
   output logic                                   rsp_full
);

   localparam int NV = mvs_pkg::NUM_VOICES;
   localparam int VW = mvs_pkg::VIDX_W;

   // configuration
   logic [15:0] mv_ff;
   logic [23:0] atk_ff, dec_ff, sus_ff, rel_ff, rels_ff;

   // latched request
   logic [1:0]  func_ff;
   logic [2:0]  rwave_ff;
   logic [31:0] rstep_ff, rdur_ff;
   logic [15:0] ramp_ff;

   // voice state
   logic [NV-1:0] active_ff;
   logic [2:0]  wave_ff [NV];
   logic [31:0] phase_ff [NV];
   logic [31:0] step_ff [NV];
   logic [15:0] amp_ff [NV];
   logic [31:0] len_ff [NV];
   logic [31:0] el_ff [NV];
   logic [23:0] lvl_ff [NV];
   mvs_pkg::env_stage_type stg_ff [NV];

   // working copy of the voice in flight
   logic [2:0]  w_wave_ff;
   logic [31:0] w_phase_ff, w_step_ff, w_len_ff, w_el_ff;
   logic [15:0] w_amp_ff;
   logic [23:0] w_lvl_ff;
   mvs_pkg::env_stage_type w_stg_ff;

   logic [mvs_pkg::MAG_W-1:0] mag_ff;
   logic neg_ff;
   logic [mvs_pkg::PROD_W-1:0] prod_ff;
   logic signed [mvs_pkg::SUM_W-1:0] sum_ff;

   // envelope step
   logic [23:0] sus;
   logic [23:0] lvl_in;
   mvs_pkg::env_stage_type stg_in;
   logic expired, freed;
   logic [24:0] att_sum, dec_lim;
   logic [32:0] rel_pos;

   always_comb begin
      sus = (sus_ff > mvs_pkg::ONE_Q23) ? mvs_pkg::ONE_Q23 : sus_ff;
      att_sum = {1'b0, w_lvl_ff} + {1'b0, atk_ff};
      dec_lim = {1'b0, sus} + {1'b0, dec_ff};
      rel_pos = {1'b0, w_el_ff} + {9'd0, rels_ff};
      expired = (w_el_ff >= w_len_ff);
      lvl_in = w_lvl_ff;
      stg_in = w_stg_ff;
      case (w_stg_ff)
         mvs_pkg::ST_ATTACK: begin
            if (att_sum >= {1'b0, mvs_pkg::ONE_Q23}) begin
               lvl_in = mvs_pkg::ONE_Q23;
               stg_in = mvs_pkg::ST_DECAY;
            end else lvl_in = att_sum[23:0];
         end
         mvs_pkg::ST_DECAY: begin
            if ({1'b0, w_lvl_ff} <= dec_lim) begin
               lvl_in = sus;
               stg_in = mvs_pkg::ST_SUSTAIN;
            end else lvl_in = w_lvl_ff - dec_ff;
         end
         mvs_pkg::ST_SUSTAIN: begin
            if (rel_pos >= {1'b0, w_len_ff}) stg_in = mvs_pkg::ST_RELEASE;
         end
         mvs_pkg::ST_RELEASE: begin
            if (w_lvl_ff <= rel_ff) begin
               lvl_in = '0;
               stg_in = mvs_pkg::ST_DONE;
            end else lvl_in = w_lvl_ff - rel_ff;
         end
         default: begin
         end
      endcase
      freed = expired || (stg_in == mvs_pkg::ST_DONE);
   end

   // wave shaper: magnitude and sign at the current phase
   logic [mvs_pkg::SINE_IDX_W-1:0] sidx;
   logic [1:0] quad;
   logic [mvs_pkg::QTR_W-1:0] qk;
   logic [mvs_pkg::QTR_W:0] qsel;
   logic [32:0] folded;
   logic [16:0] f15;
   logic [mvs_pkg::MAG_W-1:0] mag_in;
   logic neg_in;

   always_comb begin
      sidx = w_phase_ff[31 -: mvs_pkg::SINE_IDX_W];
      quad = sidx[mvs_pkg::SINE_IDX_W-1 -: 2];
      qk = sidx[mvs_pkg::QTR_W-1:0];
      qsel = quad[0] ? ((mvs_pkg::QTR_W+1)'(mvs_pkg::QTR) - {1'b0, qk}) : {1'b0, qk};
      folded = w_phase_ff[31] ? (33'h100000000 - {1'b0, w_phase_ff}) : {1'b0, w_phase_ff};
      f15 = folded[31:15];
      mag_in = '0;
      neg_in = 1'b0;
      case (w_wave_ff)
         mvs_pkg::WAVE_SINE: begin
            mag_in = mvs_pkg::SINE_TAB[qsel];
            neg_in = quad[1];
         end
         mvs_pkg::WAVE_SQUARE: begin
            mag_in = 17'd32768;
            neg_in = w_phase_ff[31];
         end
         mvs_pkg::WAVE_SAW: begin
            if (w_phase_ff[31]) mag_in = {2'b0, w_phase_ff[30:16]};
            else begin
               mag_in = 17'd32768 - {2'b0, w_phase_ff[30:16]};
               neg_in = 1'b1;
            end
         end
         mvs_pkg::WAVE_TRIANGLE: begin
            if (f15 >= 17'd32768) mag_in = f15 - 17'd32768;
            else begin
               mag_in = 17'd32768 - f15;
               neg_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // shared multiplier
   logic [33:0] mul_a;
   logic [23:0] mul_b;

   always_comb begin
      case (cmd.mul_sel)
         mvs_pkg::MUL_AMP: begin
            mul_a = 34'(mag_ff);
            mul_b = {8'd0, w_amp_ff};
         end
         mvs_pkg::MUL_ENV: begin
            mul_a = prod_ff[33:0];
            mul_b = w_lvl_ff;
         end
         mvs_pkg::MUL_VOL: begin
            mul_a = prod_ff[56:23];
            mul_b = {8'd0, mv_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // lowest free voice
   logic [VW-1:0] free_idx;
   logic any_free;

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = NV - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = VW'(i);
            any_free = 1'b1;
         end
      end
   end

   logic signed [mvs_pkg::SUM_W-1:0] contrib;
   assign contrib = $signed(mvs_pkg::SUM_W'(prod_ff[48:30]));

   assign status.func = func_ff;
   assign status.active = active_ff[cmd.vidx];
   assign status.freed = freed;

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         mv_ff <= 16'd16384;
         atk_ff <= 24'd17476;
         dec_ff <= 24'd1748;
         sus_ff <= 24'd5872026;
         rel_ff <= 24'd1748;
         rels_ff <= 24'd4800;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mvs_pkg::CSR_MASTER_VOLUME: mv_ff <= csr_data[15:0];
               mvs_pkg::CSR_ATTACK_STEP: atk_ff <= csr_data;
               mvs_pkg::CSR_DECAY_STEP: dec_ff <= csr_data;
               mvs_pkg::CSR_SUSTAIN_LEVEL: sus_ff <= csr_data;
               mvs_pkg::CSR_RELEASE_STEP: rel_ff <= csr_data;
               mvs_pkg::CSR_RELEASE_SAMPLES: rels_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.env && freed) active_ff[cmd.vidx] <= 1'b0;
         if (cmd.push) begin
            if (func_ff == mvs_pkg::FUNC_STOP) active_ff <= '0;
            else if (func_ff == mvs_pkg::FUNC_PLAY && any_free) active_ff[free_idx] <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff <= req_func;
         rwave_ff <= req_wave;
         rstep_ff <= req_step;
         ramp_ff <= req_amp;
         rdur_ff <= req_dur;
         sum_ff <= '0;
      end
      if (cmd.load) begin
         w_wave_ff <= wave_ff[cmd.vidx];
         w_phase_ff <= phase_ff[cmd.vidx];
         w_step_ff <= step_ff[cmd.vidx];
         w_amp_ff <= amp_ff[cmd.vidx];
         w_len_ff <= len_ff[cmd.vidx];
         w_el_ff <= (el_ff[cmd.vidx] == 32'hFFFFFFFF) ? el_ff[cmd.vidx]
                                                       : el_ff[cmd.vidx] + 32'd1;
         w_lvl_ff <= lvl_ff[cmd.vidx];
         w_stg_ff <= stg_ff[cmd.vidx];
      end
      if (cmd.env) begin
         w_lvl_ff <= lvl_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         el_ff[cmd.vidx] <= w_el_ff;
         lvl_ff[cmd.vidx] <= lvl_in;
         stg_ff[cmd.vidx] <= stg_in;
         phase_ff[cmd.vidx] <= w_phase_ff + w_step_ff;
      end
      if (cmd.mul_en) prod_ff <= mul_a * mul_b;
      if (cmd.acc) sum_ff <= neg_ff ? sum_ff - contrib : sum_ff + contrib;
      if (cmd.push) begin
         case (func_ff)
            mvs_pkg::FUNC_TICK: begin
               rsp_index <= '0;
               rsp_full <= 1'b0;
               if (sum_ff > mvs_pkg::SUM_W'(32767)) rsp_sample <= 16'sd32767;
               else if (sum_ff < -mvs_pkg::SUM_W'(32768)) rsp_sample <= -16'sd32768;
               else rsp_sample <= sum_ff[15:0];
            end
            mvs_pkg::FUNC_PLAY: begin
               rsp_sample <= '0;
               if (any_free) begin
                  rsp_index <= 4'(free_idx);
                  rsp_full <= 1'b0;
                  wave_ff[free_idx] <= rwave_ff;
                  phase_ff[free_idx] <= '0;
                  step_ff[free_idx] <= rstep_ff;
                  amp_ff[free_idx] <= ramp_ff;
                  len_ff[free_idx] <= rdur_ff;
                  el_ff[free_idx] <= '0;
                  lvl_ff[free_idx] <= '0;
                  stg_ff[free_idx] <= mvs_pkg::ST_ATTACK;
               end else begin
                  rsp_index <= '0;
                  rsp_full <= 1'b1;
               end
            end
            default: begin
               rsp_sample <= '0;
               rsp_index <= '0;
               rsp_full <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/multi_voice_adsr_synth_mixer_core.sv @@
// Top level of the polyphonic synth mixer: joins the sequencer and the datapath
// to the request, response and register ports. Depends on mvs_pkg and mvs_if.
`timescale 1ns / 1ps
`default_nettype none
// Sixteen-voice tone generator with a per-voice attack/decay/sustain/release
// envelope and a saturating Q1.15 mixer. Each request carries a function code:
// tick mixes one sample, play claims the lowest free voice (or reports full),
// stop frees every voice. Every request gets exactly one response. A tick visits
// the voices in turn and skips the multiplier for a voice that is idle or ends
// on this tick; for a voice that sounds, the one shared multiplier forms
// amplitude, envelope and master gain products in turn. A new request is
// taken while the previous response still waits. Registers are to be written
// only between requests; the block itself does not enforce this.
module multi_voice_adsr_synth_mixer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mvs_req_if.sink                             req_ch,
   mvs_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic [mvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mvs_pkg::CSR_DATA_W-1:0] csr_data
);

   mvs_pkg::ctrl_cmd_type cmd;
   mvs_pkg::dp_status_type status;

   // sequencer: owns both handshakes and the voice walk
   mvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds voice state, registers and the response payload
   mvs_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_func   (req_ch.func),
      .req_wave   (req_ch.wave_type),
      .req_step   (req_ch.phase_step),
      .req_amp    (req_ch.amplitude),
      .req_dur    (req_ch.duration),
      .rsp_sample (rsp_ch.sample),
      .rsp_index  (rsp_ch.voice_index),
      .rsp_full   (rsp_ch.no_free_voice)
   );

endmodule
`default_nettype wire
